FILE: rtl/core/ppr_pkg.sv
// Shared types, constants and helper functions for the panel power rail sequencer.
package ppr_pkg;

  localparam int unsigned LEVEL_W = 21;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned DELAY_W = 24;
  localparam int unsigned VGH_W   = 20;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned MODE_W  = 3;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [MODE_W-1:0]         mode_t;

  // Sequencer states, also shown on the result port.
  typedef enum logic [2:0] {
    ST_OFF       = 3'd0,
    ST_VGL_RAMP  = 3'd1,
    ST_VGH_DELAY = 3'd2,
    ST_VGH_RAMP  = 3'd3,
    ST_ALL_ON    = 3'd4
  } seq_state_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_VGH_DELAY   = 2'd0,
    CFG_VGL_TARGET  = 2'd1,
    CFG_VGH_TARGET  = 2'd2,
    CFG_TOLERANCE   = 2'd3
  } cfg_idx_t;

  // Mode codes.
  localparam mode_t MODE_ACTIVE_A = 3'd0;
  localparam mode_t MODE_ACTIVE_B = 3'd1;
  localparam mode_t MODE_ACTIVE_C = 3'd2;
  localparam mode_t MODE_VGL_ONLY = 3'd3;
  localparam mode_t MODE_STANDBY  = 3'd4;
  localparam mode_t MODE_ACTIVE_D = 3'd5;

  // Register reset values.
  localparam logic [DELAY_W-1:0] DELAY_RST   = 24'd500000;
  localparam level_t             VGL_TGT_RST = -21'sd200000;
  localparam logic [VGH_W-1:0]   VGH_TGT_RST = 20'd400000;
  localparam logic [TOL_W-1:0]   TOL_RST     = 16'd1000;

  typedef struct packed {
    logic [DELAY_W-1:0] vgh_delay_ticks;
    level_t             vgl_target_level;
    logic [VGH_W-1:0]   vgh_target_level;
    logic [TOL_W-1:0]   level_tolerance;
  } ppr_cfg_t;

  typedef struct packed {
    mode_t      reached_mode;
    logic       enable_vgl;
    logic       enable_vgh;
    logic       enable_avdd1;
    logic       enable_avdd2;
    logic       enable_dvdd;
    logic       rails_good;
    logic       sequence_error;
    seq_state_t power_state;
  } ppr_result_t;

  function automatic logic mode_needs_vgh(input mode_t m);
    return (m == MODE_ACTIVE_A) || (m == MODE_ACTIVE_B) ||
           (m == MODE_ACTIVE_C) || (m == MODE_ACTIVE_D);
  endfunction

  // Move one unit toward the target, landing on it when within one unit.
  function automatic level_t slew_one(input level_t cur, input level_t tgt);
    logic signed [LEVEL_W:0] d;
    d = {tgt[LEVEL_W-1], tgt} - {cur[LEVEL_W-1], cur};
    if ((d <= 22'sd1) && (d >= -22'sd1)) begin
      return tgt;
    end else if (d > 22'sd0) begin
      return cur + 21'sd1;
    end else begin
      return cur - 21'sd1;
    end
  endfunction

  // Two unit steps toward zero, folded into one compare and add.
  function automatic level_t slew_two_to_zero(input level_t cur);
    if ((cur <= 21'sd2) && (cur >= -21'sd2)) begin
      return '0;
    end else if (cur > 21'sd0) begin
      return cur - 21'sd2;
    end else begin
      return cur + 21'sd2;
    end
  endfunction

  function automatic logic near_target(input level_t cur, input level_t tgt,
                                       input logic [TOL_W-1:0] tol);
    logic signed [LEVEL_W:0] d;
    logic signed [LEVEL_W:0] mag;
    d   = {cur[LEVEL_W-1], cur} - {tgt[LEVEL_W-1], tgt};
    mag = (d < 22'sd0) ? -d : d;
    return $unsigned(mag) <= {{(LEVEL_W+1-TOL_W){1'b0}}, tol};
  endfunction

endpackage

FILE: rtl/core/ppr_cfg_regs.sv
// Configuration register file of the power rail sequencer.
module ppr_cfg_regs
  import ppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [DELAY_W-1:0] cfg_data,
  output ppr_cfg_t           cfg_o
);

  ppr_cfg_t cfg_r;
  ppr_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_VGH_DELAY:  cfg_nxt.vgh_delay_ticks  = cfg_data;
        CFG_VGL_TARGET: cfg_nxt.vgl_target_level = $signed(cfg_data[LEVEL_W-1:0]);
        CFG_VGH_TARGET: cfg_nxt.vgh_target_level = cfg_data[VGH_W-1:0];
        CFG_TOLERANCE:  cfg_nxt.level_tolerance  = cfg_data[TOL_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vgh_delay_ticks  <= DELAY_RST;
      cfg_r.vgl_target_level <= VGL_TGT_RST;
      cfg_r.vgh_target_level <= VGH_TGT_RST;
      cfg_r.level_tolerance  <= TOL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/ppr_seq_core.sv
// Rail level models, sequencer state machine and result decode for one tick.
module ppr_seq_core
  import ppr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  mode_t       mode,
  input  logic        vgl_ok,
  input  logic        vgh_ok,
  input  ppr_cfg_t    cfg,
  output ppr_result_t res
);

  seq_state_t        state_r, state_nxt;
  level_t            vgl_level_r, vgl_level_nxt;
  level_t            vgh_level_r, vgh_level_nxt;
  logic [TICK_W-1:0] tick_r;
  logic [TICK_W-1:0] stamp_r, stamp_nxt;
  mode_t             reached_r, reached_nxt;

  logic   need_vgh, en_vgl, en_vgh, pgood;
  logic   vgl_near, vgh_near, stamp_taken, elapsed_ok, in_delay_grp;
  level_t vgh_tgt, vgh_up, vgh_dn, vgh_dn2;
  seq_state_t st_vgl;
  mode_t      reached_vgl;

  // Level and decode logic.
  always_comb begin
    need_vgh      = mode_needs_vgh(mode);
    en_vgl        = need_vgh || (mode == MODE_VGL_ONLY);
    vgl_level_nxt = slew_one(vgl_level_r, en_vgl ? cfg.vgl_target_level : '0);
    vgl_near      = near_target(vgl_level_nxt, cfg.vgl_target_level, cfg.level_tolerance);
    vgh_tgt       = {1'b0, cfg.vgh_target_level};
    vgh_up        = slew_one(vgh_level_r, vgh_tgt);
    vgh_dn        = slew_one(vgh_level_r, '0);
    vgh_dn2       = slew_two_to_zero(vgh_level_r);
    vgh_near      = near_target(vgh_up, vgh_tgt, cfg.level_tolerance);
  end

  // Next state.
  always_comb begin
    st_vgl      = state_r;
    stamp_nxt   = stamp_r;
    reached_vgl = reached_r;
    stamp_taken = 1'b0;
    if (!en_vgl) begin
      st_vgl    = ST_OFF;
      stamp_nxt = '0;
    end else if (!vgl_near || !vgl_ok) begin
      st_vgl    = ST_VGL_RAMP;
      stamp_nxt = '0;
    end else if (!need_vgh) begin
      st_vgl      = ST_VGH_DELAY;
      reached_vgl = mode;
    end else if ((state_r == ST_OFF) || (state_r == ST_VGL_RAMP)) begin
      st_vgl      = ST_VGH_DELAY;
      stamp_nxt   = tick_r;
      stamp_taken = 1'b1;
    end

    // A stamp taken this tick means zero elapsed ticks.
    elapsed_ok   = stamp_taken ? (cfg.vgh_delay_ticks == '0)
                               : ((tick_r - stamp_r) >= {8'd0, cfg.vgh_delay_ticks});
    in_delay_grp = need_vgh && ((st_vgl == ST_VGH_DELAY) || (st_vgl == ST_VGH_RAMP) ||
                                (st_vgl == ST_ALL_ON));
    en_vgh       = in_delay_grp && elapsed_ok;
    pgood        = en_vgh && vgh_near && vgh_ok;

    if (pgood) begin
      state_nxt = ST_ALL_ON;
    end else if (en_vgh) begin
      state_nxt = ST_VGH_RAMP;
    end else begin
      state_nxt = st_vgl;
    end

    if (mode == MODE_STANDBY) begin
      reached_nxt = MODE_STANDBY;
    end else if (pgood) begin
      reached_nxt = mode;
    end else begin
      reached_nxt = reached_vgl;
    end

    if (en_vgh) begin
      vgh_level_nxt = vgh_up;
    end else if (need_vgh) begin
      vgh_level_nxt = vgh_dn;
    end else begin
      vgh_level_nxt = vgh_dn2;
    end
  end

  // Result outputs.
  always_comb begin
    res.reached_mode   = reached_nxt;
    res.enable_vgl     = en_vgl;
    res.enable_vgh     = en_vgh;
    res.enable_avdd1   = (mode != MODE_STANDBY);
    res.enable_avdd2   = need_vgh;
    res.enable_dvdd    = 1'b1;
    res.rails_good     = pgood;
    res.sequence_error = en_vgh && !en_vgl;
    res.power_state    = state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_OFF;
      vgl_level_r <= '0;
      vgh_level_r <= '0;
      tick_r      <= '0;
      stamp_r     <= '0;
      reached_r   <= '0;
    end else if (step) begin
      state_r     <= state_nxt;
      vgl_level_r <= vgl_level_nxt;
      vgh_level_r <= vgh_level_nxt;
      tick_r      <= tick_r + 32'd1;
      stamp_r     <= stamp_nxt;
      reached_r   <= reached_nxt;
    end
  end

endmodule

FILE: rtl/core/panel_power_rail_sequencer.sv
// Top level of the panel power rail sequencer: request registers, core and result register.
//
//  channel   direction  handshake               payload
//  in_       request    in_valid / in_ready     requested mode, vgl/vgh_rail_stable
//  out_      result     out_valid / out_ready   reached_mode, enables, status, state
//  cfg_      write      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each request is one sequencer tick and yields exactly one result.
// A request is captured in the input register, evaluated combinationally by the
// core, and its result lands in the output register; one request per cycle is
// sustained while out_ready stays high.
// The rail levels, tick counter, settle stamp and state advance only when a
// request moves from the input register into the output register.
// When out_ready is low the output register holds, the input register fills,
// and in_ready drops; nothing is dropped or repeated.
// Reset is synchronous and active low; the configuration port is always ready.
module panel_power_rail_sequencer
  import ppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_mode,
  input  logic               in_vgl_rail_stable,
  input  logic               in_vgh_rail_stable,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_reached_mode,
  output logic               out_enable_vgl,
  output logic               out_enable_vgh,
  output logic               out_enable_avdd1,
  output logic               out_enable_avdd2,
  output logic               out_enable_dvdd,
  output logic               out_rails_good,
  output logic               out_sequence_error,
  output logic [2:0]         out_power_state,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [DELAY_W-1:0] cfg_data
);

  logic        s1_valid_r;
  mode_t       s1_mode_r;
  logic        s1_vgl_ok_r;
  logic        s1_vgh_ok_r;
  logic        out_valid_r;
  ppr_result_t out_res_r;
  ppr_result_t core_res;
  ppr_cfg_t    cfg;
  logic        advance;

  // The input register drains whenever the output register is free or emptying.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  ppr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ppr_seq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .mode   (s1_mode_r),
    .vgl_ok (s1_vgl_ok_r),
    .vgh_ok (s1_vgh_ok_r),
    .cfg    (cfg),
    .res    (core_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r   <= in_req_mode;
      s1_vgl_ok_r <= in_vgl_rail_stable;
      s1_vgh_ok_r <= in_vgh_rail_stable;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reached_mode   = out_res_r.reached_mode;
  assign out_enable_vgl     = out_res_r.enable_vgl;
  assign out_enable_vgh     = out_res_r.enable_vgh;
  assign out_enable_avdd1   = out_res_r.enable_avdd1;
  assign out_enable_avdd2   = out_res_r.enable_avdd2;
  assign out_enable_dvdd    = out_res_r.enable_dvdd;
  assign out_rails_good     = out_res_r.rails_good;
  assign out_sequence_error = out_res_r.sequence_error;
  assign out_power_state    = out_res_r.power_state;

endmodule

FILE: rtl/core/ppr_checker.sv
// Port-level assertions for the panel power rail sequencer, bound to the top level.
module ppr_checker
  import ppr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_reached_mode,
  input logic       out_enable_vgl,
  input logic       out_enable_vgh,
  input logic       out_enable_dvdd,
  input logic       out_rails_good,
  input logic [2:0] out_power_state
);

  // The positive rail is never enabled without the negative rail.
  a_vgh_needs_vgl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enable_vgh |-> out_enable_vgl)
    else $error("positive rail enabled without negative rail");

  // Power good only in the all-on state with the positive rail enabled.
  a_pgood_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rails_good |-> (out_power_state == ST_ALL_ON) && out_enable_vgh)
    else $error("power good outside the all-on state");

  // The off state and a disabled negative rail always go together.
  a_off_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_power_state == ST_OFF) == !out_enable_vgl))
    else $error("off state disagrees with negative rail enable");

  // The digital supply is always enabled.
  a_dvdd_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_enable_dvdd)
    else $error("digital supply enable low");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reached_mode) &&
                                $stable(out_power_state))
    else $error("stalled result changed");

endmodule

bind panel_power_rail_sequencer ppr_checker u_ppr_checker (.*);

FILE: dv/panel_power_rail_sequencer_tb.sv
// Self-checking testbench for the panel power rail sequencer, with a tick-accurate predictor.
import ppr_pkg::*;

class rail_sequence_tracker;
  logic [DELAY_W-1:0] delay_ticks;
  int vgl_goal;
  int vgh_goal;
  int tolerance;
  seq_state_t state;
  int vgl_lvl;
  int vgh_lvl;
  logic [TICK_W-1:0] tick_now;
  logic [TICK_W-1:0] settle_tick;
  mode_t reached;
  ppr_result_t awaited_status[$];
  int errors;
  int checked;
  int good_ticks;
  int all_on_ticks;

  function new();
    delay_ticks  = DELAY_RST;
    vgl_goal     = VGL_TGT_RST;
    vgh_goal     = int'(VGH_TGT_RST);
    tolerance    = int'(TOL_RST);
    state        = ST_OFF;
    vgl_lvl      = 0;
    vgh_lvl      = 0;
    tick_now     = '0;
    settle_tick  = '0;
    reached      = '0;
    errors       = 0;
    checked      = 0;
    good_ticks   = 0;
    all_on_ticks = 0;
  endfunction

  function int pending();
    return awaited_status.size();
  endfunction

  function void write_reg(cfg_idx_t idx, logic [DELAY_W-1:0] data);
    level_t vgl_bits;
    case (idx)
      CFG_VGH_DELAY:  delay_ticks = data;
      CFG_VGL_TARGET: begin
        vgl_bits = data[LEVEL_W-1:0];
        vgl_goal = vgl_bits;
      end
      CFG_VGH_TARGET: vgh_goal = int'(data[VGH_W-1:0]);
      CFG_TOLERANCE:  tolerance = int'(data[TOL_W-1:0]);
      default: ;
    endcase
  endfunction

  function int step_toward(int cur, int goal);
    if ((goal - cur <= 1) && (goal - cur >= -1)) return goal;
    return (goal > cur) ? cur + 1 : cur - 1;
  endfunction

  function bit at_goal(int cur, int goal);
    int gap;
    gap = cur - goal;
    if (gap < 0) gap = -gap;
    return gap <= tolerance;
  endfunction

  // Advances the rail model by one tick and queues the status it should produce.
  function void note_request(mode_t mode, logic vgl_ok, logic vgh_ok);
    ppr_result_t r;
    logic [TICK_W-1:0] elapsed;
    bit both_rails;
    bit vgl_on;
    bit vgh_on;
    bit good;
    both_rails = (mode == MODE_ACTIVE_A) || (mode == MODE_ACTIVE_B) ||
                 (mode == MODE_ACTIVE_C) || (mode == MODE_ACTIVE_D);
    vgl_on = both_rails || (mode == MODE_VGL_ONLY);
    vgh_on = 1'b0;
    good   = 1'b0;

    vgl_lvl = step_toward(vgl_lvl, vgl_on ? vgl_goal : 0);
    if (!vgl_on) begin
      state = ST_OFF;
      settle_tick = '0;
    end else if (!at_goal(vgl_lvl, vgl_goal) || !vgl_ok) begin
      state = ST_VGL_RAMP;
      settle_tick = '0;
    end else if (!both_rails) begin
      state = ST_VGH_DELAY;
      reached = mode;
    end else if ((state == ST_OFF) || (state == ST_VGL_RAMP)) begin
      state = ST_VGH_DELAY;
      settle_tick = tick_now;
    end

    // The delay is measured modulo the tick counter width.
    elapsed = tick_now - settle_tick;
    if (both_rails && (state != ST_OFF) && (state != ST_VGL_RAMP) &&
        (elapsed >= {{(TICK_W-DELAY_W){1'b0}}, delay_ticks})) begin
      vgh_on = 1'b1;
      state = ST_VGH_RAMP;
    end

    vgh_lvl = step_toward(vgh_lvl, vgh_on ? vgh_goal : 0);
    if (both_rails && vgh_on && at_goal(vgh_lvl, vgh_goal) && vgh_ok) begin
      state = ST_ALL_ON;
      reached = mode;
      good = 1'b1;
    end else if (!both_rails) begin
      vgh_lvl = step_toward(vgh_lvl, 0);
    end
    if (mode == MODE_STANDBY) reached = MODE_STANDBY;
    tick_now = tick_now + 1'b1;

    r.reached_mode   = reached;
    r.enable_vgl     = vgl_on;
    r.enable_vgh     = vgh_on;
    r.enable_avdd1   = (mode != MODE_STANDBY);
    r.enable_avdd2   = both_rails;
    r.enable_dvdd    = 1'b1;
    r.rails_good     = good;
    r.sequence_error = vgh_on && !vgl_on;
    r.power_state    = state;
    awaited_status.insert(awaited_status.size(), r);
    if (good) good_ticks++;
    if (state == ST_ALL_ON) all_on_ticks++;
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at result %0d: %s", checked, what);
    errors++;
  endtask

  task compare_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task check_result(ppr_result_t got);
    ppr_result_t want;
    if (awaited_status.size() == 0) begin
      report_mismatch("status arrived with no request outstanding");
    end else begin
      want = awaited_status.pop_front();
      compare_field("reached_mode", got.reached_mode, want.reached_mode);
      compare_field("enable_vgl", got.enable_vgl, want.enable_vgl);
      compare_field("enable_vgh", got.enable_vgh, want.enable_vgh);
      compare_field("enable_avdd1", got.enable_avdd1, want.enable_avdd1);
      compare_field("enable_avdd2", got.enable_avdd2, want.enable_avdd2);
      compare_field("enable_dvdd", got.enable_dvdd, want.enable_dvdd);
      compare_field("rails_good", got.rails_good, want.rails_good);
      compare_field("sequence_error", got.sequence_error, want.sequence_error);
      compare_field("power_state", got.power_state, want.power_state);
    end
    checked++;
  endtask
endclass

module panel_power_rail_sequencer_tb;

  // Modes 6 and 7 have no name in the package; they are the unused codes.
  localparam mode_t MODE_UNUSED_6 = 3'd6;
  localparam mode_t MODE_UNUSED_7 = 3'd7;

  // The longest quiet stretch of a correct run is a sender gap plus a receiver
  // stall plus the passage through the input and output registers.
  localparam int WATCHDOG_LIMIT = 2000;

  // Kinds of register setting used between phases of the random part.
  typedef enum int {
    SET_SMALL,    // small targets and delay, so full sequences complete quickly
    SET_HIGHEST,  // every register at the extreme of its range, the VGL target most negative
    SET_ZERO,     // every register at zero
    SET_LOOSE,    // no delay and the widest tolerance
    SET_WILD      // fully random register words, upper bits included
  } setting_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_req_mode = '0;
  logic                in_vgl_rail_stable = 1'b0;
  logic                in_vgh_rail_stable = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_reached_mode;
  logic                out_enable_vgl;
  logic                out_enable_vgh;
  logic                out_enable_avdd1;
  logic                out_enable_avdd2;
  logic                out_enable_dvdd;
  logic                out_rails_good;
  logic                out_sequence_error;
  logic [2:0]          out_power_state;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [DELAY_W-1:0]  cfg_data = '0;

  rail_sequence_tracker tracker = new();

  bit idle_en = 1'b0;     // when clear, neither side inserts idle cycles
  int stall_left = 0;     // remaining cycles of the current receiver stall
  int quiet_cycles = 0;
  int sent = 0;
  int settings = 0;

  panel_power_rail_sequencer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_mode        (in_req_mode),
    .in_vgl_rail_stable (in_vgl_rail_stable),
    .in_vgh_rail_stable (in_vgh_rail_stable),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reached_mode   (out_reached_mode),
    .out_enable_vgl     (out_enable_vgl),
    .out_enable_vgh     (out_enable_vgh),
    .out_enable_avdd1   (out_enable_avdd1),
    .out_enable_avdd2   (out_enable_avdd2),
    .out_enable_dvdd    (out_enable_dvdd),
    .out_rails_good     (out_rails_good),
    .out_sequence_error (out_sequence_error),
    .out_power_state    (out_power_state),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls in bursts while idling is on.
  // The burst counter is private to this process, so it is updated at once.
  always @(posedge clk) begin
    if ((stall_left == 0) && idle_en && ($urandom_range(0, 5) == 0))
      stall_left = $urandom_range(1, 8);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every status accepted at a rising edge is checked against the oldest
  // prediction. Outputs are read before the edge's updates take effect.
  always @(posedge clk) begin : result_monitor
    ppr_result_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.reached_mode   = out_reached_mode;
      seen.enable_vgl     = out_enable_vgl;
      seen.enable_vgh     = out_enable_vgh;
      seen.enable_avdd1   = out_enable_avdd1;
      seen.enable_avdd2   = out_enable_avdd2;
      seen.enable_dvdd    = out_enable_dvdd;
      seen.rails_good     = out_rails_good;
      seen.sequence_error = out_sequence_error;
      seen.power_state    = seq_state_t'(out_power_state);
      tracker.check_result(seen);
    end
  end

  // The watchdog ends a run in which no channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles.", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request (one sequencer tick) and waits for its acceptance.
  // At the accepting edge valid is left high, so a following request can be
  // presented in the same step without valid ever dropping in between.
  task automatic send_tick(mode_t mode, logic vgl_ok, logic vgh_ok);
    if (idle_en && ($urandom_range(0, 4) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req_mode        <= mode;
    in_vgl_rail_stable <= vgl_ok;
    in_vgh_rail_stable <= vgh_ok;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(mode, vgl_ok, vgh_ok);
    sent++;
  endtask

  task automatic run_mode(mode_t mode, logic vgl_ok, logic vgh_ok, int reps);
    repeat (reps) send_tick(mode, vgl_ok, vgh_ok);
  endtask

  // Withdraws the request channel and waits until every status has come back,
  // so that the sequencer holds nothing while its registers change.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high after the write so that back-to-back writes never
  // drop it within one step; the caller lowers it after the last write.
  task automatic put_reg(cfg_idx_t idx, logic [DELAY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_settings(logic [DELAY_W-1:0] d_delay, logic [DELAY_W-1:0] d_vgl,
                               logic [DELAY_W-1:0] d_vgh, logic [DELAY_W-1:0] d_tol);
    wait_idle();
    put_reg(CFG_VGH_DELAY, d_delay);
    put_reg(CFG_VGL_TARGET, d_vgl);
    put_reg(CFG_VGH_TARGET, d_vgh);
    put_reg(CFG_TOLERANCE, d_tol);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Builds one register setting of the given kind. Bits above each register's
  // width are filled at random except in the zero kind, since the block is meant to ignore them.
  task automatic load_kind(setting_kind_t kind);
    logic [7:0]         spare;
    level_t             vgl_bits;
    logic [VGH_W-1:0]   vgh_bits;
    logic [TOL_W-1:0]   tol_bits;
    logic [DELAY_W-1:0] delay_bits;
    int                 depth;
    spare      = 8'($urandom);
    depth      = $urandom_range(0, 24);
    vgl_bits   = level_t'(-depth);
    vgh_bits   = VGH_W'($urandom_range(0, 32));
    tol_bits   = TOL_W'($urandom_range(0, 5));
    delay_bits = DELAY_W'($urandom_range(0, 16));
    case (kind)
      SET_HIGHEST: load_settings({DELAY_W{1'b1}}, {spare[2:0], 1'b1, {(LEVEL_W-1){1'b0}}},
                                 {spare[7:4], {VGH_W{1'b1}}}, {spare, {TOL_W{1'b1}}});
      SET_ZERO:    load_settings('0, '0, '0, '0);
      SET_LOOSE:   load_settings('0, {spare[2:0], vgl_bits}, {spare[7:4], vgh_bits},
                                 {spare, {TOL_W{1'b1}}});
      SET_WILD:    load_settings(DELAY_W'($urandom), DELAY_W'($urandom),
                                 DELAY_W'($urandom), DELAY_W'($urandom));
      default:     load_settings(delay_bits, {spare[2:0], vgl_bits}, {spare[7:4], vgh_bits},
                                 {spare, tol_bits});
    endcase
  endtask

  // Mostly well-formed stretches: one mode held for a while with the stable
  // flags usually high, so ramps, the delay and the all-on state are reached.
  // Short noise requests with fully random fields break the stretches now and then.
  task automatic run_sequences(int count);
    int    left;
    int    hold;
    int    pick;
    mode_t mode;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        case ($urandom_range(0, 3))
          0:       mode = MODE_ACTIVE_A;
          1:       mode = MODE_ACTIVE_B;
          2:       mode = MODE_ACTIVE_C;
          default: mode = MODE_ACTIVE_D;
        endcase
      end else if (pick < 16) begin
        mode = MODE_VGL_ONLY;
      end else if (pick < 18) begin
        mode = MODE_STANDBY;
      end else begin
        mode = mode_t'($urandom_range(0, 7));
      end
      hold = $urandom_range(3, 60);
      if (hold > left) hold = left;
      repeat (hold) begin
        if ($urandom_range(0, 24) == 0)
          send_tick(mode_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          send_tick(mode, $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0);
        left--;
      end
    end
  endtask

  initial begin
    setting_kind_t kind;

    // Synchronous reset held from the start, then released once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    idle_en = 1'b1;

    // A few ticks under the reset register values: the rails only start to
    // ramp, which shows the reset targets, delay and tolerance are in place.
    send_tick(MODE_ACTIVE_A, 1'b1, 1'b1);
    send_tick(MODE_VGL_ONLY, 1'b1, 1'b1);
    send_tick(MODE_STANDBY, 1'b1, 1'b1);
    send_tick(MODE_UNUSED_7, 1'b1, 1'b1);

    // Directed walk with tiny targets. The negative-only mode settles first,
    // then a switch to a two-rail mode must reuse the stored settle stamp
    // instead of taking a new one, so the positive rail turns on at once.
    load_kind(SET_SMALL);
    load_settings(24'd2, {3'b000, -21'sd4}, 24'd6, 24'd1);
    run_mode(MODE_VGL_ONLY, 1'b1, 1'b1, 5);
    run_mode(MODE_ACTIVE_A, 1'b1, 1'b1, 6);
    // Losing either stable flag drops power good, or the whole sequence.
    run_mode(MODE_ACTIVE_A, 1'b1, 1'b0, 1);
    run_mode(MODE_ACTIVE_B, 1'b0, 1'b1, 1);
    // Standby forces the reached mode and pulls the positive rail down fast.
    run_mode(MODE_STANDBY, 1'b0, 1'b0, 3);
    // Unused modes turn the gate rails off and keep the reached mode.
    run_mode(MODE_UNUSED_6, 1'b1, 1'b1, 1);
    run_mode(MODE_UNUSED_7, 1'b1, 1'b1, 1);
    run_mode(MODE_ACTIVE_D, 1'b1, 1'b1, 2);
    run_mode(MODE_ACTIVE_C, 1'b1, 1'b1, 2);

    // Random phases, each under a new register setting written while idle.
    // The rail levels carry over, so targets also change in the middle of ramps.
    // The last two phases run without any idle cycles on either side.
    for (int p = 0; p < 16; p++) begin
      case (p)
        3:       kind = SET_HIGHEST;
        6:       kind = SET_ZERO;
        9:       kind = SET_LOOSE;
        12:      kind = SET_WILD;
        default: kind = SET_SMALL;
      endcase
      load_kind(kind);
      idle_en = (p < 14) && ($urandom_range(0, 3) != 0);
      run_sequences((kind == SET_SMALL) ? 60 : 30);
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests under %0d register settings, range extremes included.",
             sent, settings);
    $display("Checked %0d results: power good on %0d ticks, all-on on %0d ticks, %0d mismatches.",
             tracker.checked, tracker.good_ticks, tracker.all_on_ticks, tracker.errors);
    if ((tracker.errors == 0) && (tracker.pending() == 0)) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
